FILE: rtl/rph_pkg.sv
// Package for the radar projection histogram: payload structs, command and
// state codes, and default sizes. No dependencies.
package rph_pkg;

  localparam int FRAME_SIDE_DEF  = 256;
  localparam int QUEUE_DEPTH_DEF = 4;
  // Widest bin index over the supported frame sides (1024 x 1024 bins).
  localparam int MAX_IDX_W       = 20;

  typedef enum logic [1:0] {
    FUNC_ACC   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] left_coord;
    logic [15:0] right_coord;
    logic [15:0] depth;
    logic [15:0] weight;
    logic [15:0] read_addr;
  } rph_in_t;

  typedef struct packed {
    logic [31:0] bin_value;
    logic [31:0] frame_max;
  } rph_out_t;

  // One queued command for the back end.
  typedef struct packed {
    op_t                  op;
    logic                 l_hit;
    logic                 r_hit;
    logic [MAX_IDX_W-1:0] l_idx;
    logic [MAX_IDX_W-1:0] r_idx;
    logic [15:0]          weight;
    logic                 rd_ok;
    logic [MAX_IDX_W-1:0] rd_idx;
  } rph_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rph_q_status_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_L_RD,
    BK_L_WR,
    BK_R_RD,
    BK_R_WR,
    BK_RD_RD,
    BK_RESP
  } back_state_t;

endpackage

FILE: rtl/rph_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rph_front.sv
// Front end: accepts items, bins the coordinates and builds queue commands.
// Depends on rph_pkg.
module rph_front import rph_pkg::*; #(
  parameter int FRAME_SIDE = FRAME_SIDE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  rph_in_t       pixel,
  input  logic          pixel_valid,
  output logic          pixel_ready,
  input  logic          clearing,
  input  rph_q_status_t q_stat,
  output logic          q_push,
  output rph_cmd_t      q_data
);

  localparam int SIDE_W    = $clog2(FRAME_SIDE);
  localparam int IDX_W     = $clog2(FRAME_SIDE * FRAME_SIDE);
  localparam int PROD_W    = 17 + SIDE_W;
  localparam int HALF      = FRAME_SIDE / 2;
  localparam int BIN_COUNT = FRAME_SIDE * FRAME_SIDE;

  // stage A: bins
  logic                 a_valid;
  op_t                  a_op;
  logic                 a_l_hit;
  logic                 a_r_hit;
  logic [SIDE_W-1:0]    a_row;
  logic [SIDE_W-1:0]    a_lcol;
  logic [SIDE_W-1:0]    a_rcol;
  logic [15:0]          a_weight;
  logic                 a_rd_ok;
  logic [MAX_IDX_W-1:0] a_rd_idx;

  // stage B: finished command
  logic                 b_valid;
  rph_cmd_t             b_cmd;

  logic                 a_free;
  logic                 b_free;
  logic                 accept;
  logic                 keep;
  op_t                  op_c;
  logic                 l_hit_c;
  logic                 r_hit_c;
  logic [16:0]          l_inv;
  logic [PROD_W-1:0]    row_prod;
  logic [PROD_W-1:0]    lcol_prod;
  logic [PROD_W-1:0]    rcol_prod;
  logic [IDX_W-1:0]     row_base;

  assign b_free      = !b_valid || !q_stat.full;
  assign a_free      = !a_valid || b_free;
  assign pixel_ready = a_free && !clearing;
  assign accept      = pixel_valid && pixel_ready;
  assign q_push      = b_valid && !q_stat.full;
  assign q_data      = b_cmd;

  assign l_hit_c   = (pixel.depth != 16'd0) && (pixel.left_coord != 16'd0);
  assign r_hit_c   = (pixel.depth != 16'd0) && (pixel.right_coord != 16'd0);
  assign l_inv     = 17'h10000 - {1'b0, pixel.left_coord};
  assign row_prod  = PROD_W'(pixel.depth) * PROD_W'(FRAME_SIDE);
  assign lcol_prod = PROD_W'(l_inv) * PROD_W'(FRAME_SIDE);
  assign rcol_prod = PROD_W'(pixel.right_coord) * PROD_W'(FRAME_SIDE);

  always_comb begin
    keep = 1'b0;
    op_c = OP_ACC;
    unique case (pixel.func)
      FUNC_ACC: begin
        op_c = OP_ACC;
        keep = l_hit_c || r_hit_c;
      end
      FUNC_READ: begin
        op_c = OP_READ;
        keep = 1'b1;
      end
      FUNC_CLEAR: begin
        op_c = OP_CLEAR;
        keep = 1'b1;
      end
      default: begin
        // unused code: taken and dropped
        op_c = OP_ACC;
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= accept && keep;
    end
    if (a_free) begin
      a_op     <= op_c;
      a_l_hit  <= l_hit_c;
      a_r_hit  <= r_hit_c;
      a_row    <= SIDE_W'(row_prod >> 16);
      a_lcol   <= SIDE_W'(lcol_prod >> 17);
      a_rcol   <= SIDE_W'(HALF) + SIDE_W'(rcol_prod >> 17);
      a_weight <= pixel.weight;
      a_rd_ok  <= 32'(pixel.read_addr) < 32'(BIN_COUNT);
      a_rd_idx <= MAX_IDX_W'(pixel.read_addr);
    end
  end

  assign row_base = IDX_W'(a_row) * IDX_W'(FRAME_SIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
    if (b_free && a_valid) begin
      b_cmd.op     <= a_op;
      b_cmd.l_hit  <= a_l_hit;
      b_cmd.r_hit  <= a_r_hit;
      b_cmd.l_idx  <= MAX_IDX_W'(row_base + IDX_W'(a_lcol));
      b_cmd.r_idx  <= MAX_IDX_W'(row_base + IDX_W'(a_rcol));
      b_cmd.weight <= a_weight;
      b_cmd.rd_ok  <= a_rd_ok;
      b_cmd.rd_idx <= a_rd_idx;
    end
  end

endmodule

FILE: rtl/rph_queue.sv
// Short command queue between front and back end.
// Depends on rph_pkg.
module rph_queue import rph_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rph_cmd_t      push_data,
  input  logic          pop,
  output rph_cmd_t      head,
  output rph_q_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rph_cmd_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> !status.empty)
    else $error("queue empty after a push");

endmodule

FILE: rtl/rph_back.sv
// Back end: read-modify-write of the bin RAM, peak tracking, clear sweep
// and result register. Depends on rph_pkg; drives an rph_ram instance.
module rph_back import rph_pkg::*; #(
  parameter int FRAME_SIDE = FRAME_SIDE_DEF,
  localparam int IDX_W = $clog2(FRAME_SIDE * FRAME_SIDE)
) (
  input  logic             clk,
  input  logic             rst,
  input  rph_q_status_t    q_stat,
  input  rph_cmd_t         q_head,
  output logic             q_pop,
  output logic             clearing,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output logic [31:0]      ram_wdata,
  output logic             ram_re,
  output logic [IDX_W-1:0] ram_raddr,
  input  logic [31:0]      ram_rdata,
  output rph_out_t         result,
  output logic             result_valid,
  input  logic             result_ready
);

  localparam logic [IDX_W-1:0] BIN_LAST = IDX_W'(FRAME_SIDE * FRAME_SIDE - 1);

  back_state_t      state;
  back_state_t      state_next;
  rph_cmd_t         cur;
  logic [IDX_W-1:0] clr_cnt;
  logic [31:0]      peak;
  logic [32:0]      sum;
  logic [31:0]      sat_sum;
  logic             out_load;
  logic             upd;

  assign sum     = {1'b0, ram_rdata} + 33'(cur.weight);
  assign sat_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if (clr_cnt == BIN_LAST) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_stat.empty) begin
          unique case (q_head.op)
            OP_ACC:   state_next = q_head.l_hit ? BK_L_RD : BK_R_RD;
            OP_READ:  state_next = BK_RD_RD;
            OP_CLEAR: state_next = BK_CLEAR;
            default:  state_next = BK_IDLE;
          endcase
        end
      end
      BK_L_RD:  state_next = BK_L_WR;
      BK_L_WR:  state_next = cur.r_hit ? BK_R_RD : BK_IDLE;
      BK_R_RD:  state_next = BK_R_WR;
      BK_R_WR:  state_next = BK_IDLE;
      BK_RD_RD: state_next = BK_RESP;
      BK_RESP: begin
        if (!result_valid || result_ready) state_next = BK_IDLE;
      end
      default:  state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    clearing  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cur.l_idx[IDX_W-1:0];
    out_load  = 1'b0;
    upd       = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        clearing = 1'b1;
        ram_we   = 1'b1;
      end
      BK_IDLE: begin
        q_pop = !q_stat.empty;
      end
      BK_L_RD: begin
        ram_re = 1'b1;
      end
      BK_L_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cur.l_idx[IDX_W-1:0];
        ram_wdata = sat_sum;
        upd       = 1'b1;
      end
      BK_R_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cur.r_idx[IDX_W-1:0];
      end
      BK_R_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cur.r_idx[IDX_W-1:0];
        ram_wdata = sat_sum;
        upd       = 1'b1;
      end
      BK_RD_RD: begin
        ram_re    = cur.rd_ok;
        ram_raddr = cur.rd_idx[IDX_W-1:0];
      end
      BK_RESP: begin
        out_load = !result_valid || result_ready;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_CLEAR;
      clr_cnt      <= '0;
      peak         <= '0;
      result_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= (state == BK_CLEAR) ? clr_cnt + 1'b1 : '0;
      if (state == BK_CLEAR) begin
        peak <= '0;
      end else if (upd && (sat_sum > peak)) begin
        peak <= sat_sum;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (q_pop) begin
      cur <= q_head;
    end
    if (out_load) begin
      // ram_rdata still holds the word fetched in BK_RD_RD
      result.bin_value <= cur.rd_ok ? ram_rdata : 32'd0;
      result.frame_max <= peak;
    end
  end

  a_peak_rises: assert property (@(posedge clk) disable iff (rst)
    ($past(state) != BK_CLEAR) |-> (peak >= $past(peak)))
    else $error("peak dropped outside a clear");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == BK_L_WR || state == BK_R_WR) |->
      ($past(state) == BK_L_RD || $past(state) == BK_R_RD))
    else $error("bin write without a preceding read");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == BK_RESP))
    else $error("result raised outside the response state");

endmodule

FILE: rtl/radar_projection_histogram_top.sv
// Top level of the radar projection histogram.
// Depends on rph_pkg, rph_front, rph_queue, rph_back and rph_ram.
//
// Two-dimensional weighted histogram of rendered pixels over a
// FRAME_SIDE x FRAME_SIDE bin RAM. An accumulate item bins its left coordinate
// into the left half and its right coordinate into the right half, with the
// depth selecting the row, and adds the weight (saturating at 2^32-1) to each
// bin whose coordinate and depth are nonzero; a running maximum over all bins
// is kept. A read item returns the addressed bin (zero beyond the store) and
// that maximum; a clear item zeroes the store and the maximum. The front end
// takes one item per cycle while pixel_ready is high, bins it in two pipeline
// stages and queues a command; items that do nothing (misses, unused code)
// are dropped there at full rate. The back end runs one command at a time
// against the bin RAM (one write port, one read port) as read-modify-write:
// an accumulate reads and then writes each hit bin, a read fetches the bin
// and then waits for the result register to be free, a clear writes zero to
// every bin in turn. After reset the back end sweeps all FRAME_SIDE*FRAME_SIDE
// bins (65536 at the default side) to zero; during that sweep and during a
// clear, pixel_ready is low. Sustained rate is therefore set by the RAM
// read-modify-write sequence, with the queue absorbing short bursts.
module radar_projection_histogram_top import rph_pkg::*; #(
  parameter int FRAME_SIDE  = FRAME_SIDE_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  rph_in_t  pixel,
  input  logic     pixel_valid,
  output logic     pixel_ready,
  output rph_out_t result,
  output logic     result_valid,
  input  logic     result_ready
);

  localparam int BIN_COUNT = FRAME_SIDE * FRAME_SIDE;
  localparam int IDX_W     = $clog2(BIN_COUNT);

  // front to queue
  logic          q_push;
  rph_cmd_t      q_in;
  // queue to back
  rph_cmd_t      q_head;
  logic          q_pop;
  rph_q_status_t q_stat;
  // back end status: clear sweep running
  logic          clearing;

  // bin RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  rph_front #(
    .FRAME_SIDE(FRAME_SIDE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .clearing   (clearing),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  rph_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_stat)
  );

  rph_back #(
    .FRAME_SIDE(FRAME_SIDE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .result      (result),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

  // bin store
  rph_ram #(
    .WIDTH(32),
    .DEPTH(BIN_COUNT)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
